// ===== hdl/ccr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ccr_pkg: shared types and constants for the closed Catmull-Rom evaluator
// Transaction payloads, point store geometry, datapath widths and the
// control groups that pass between the top level and the axis lanes.
// ---------------------------------------------------------------------------
package ccr_pkg;

  // Point store geometry
  localparam int MAX_POINTS = 64;
  localparam int PT_IDX_W   = $clog2(MAX_POINTS);
  localparam int CNT_W      = 7;
  localparam int NUM_AXES   = 3;
  localparam int NUM_TAPS   = 4;

  // Datapath widths
  localparam int COORD_W = 32;
  localparam int T_W     = 16;
  localparam int ACC_W   = COORD_W + 6;
  localparam int PROD_W  = ACC_W + T_W + 1;

  // Pipeline depth, input register through output register
  localparam int NUM_STAGES = 10;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(4);

  typedef enum logic [CFG_ADDR_W-3:0] {
    REG_POINT_COUNT = 1'b0
  } cfg_reg_t;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_EVAL = 1'b1
  } kind_t;

  typedef struct packed {
    logic                      kind;
    logic [PT_IDX_W-1:0]       point_slot;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [T_W-1:0]            global_t;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] tangent_x;
    logic signed [COORD_W-1:0] tangent_y;
    logic signed [COORD_W-1:0] tangent_z;
    logic                      clipped;
  } out_item_t;

  // One stored point, axis 0 is x
  typedef logic [NUM_AXES-1:0][COORD_W-1:0] point_t;

  // One axis of the four taps P0..P3
  typedef logic [NUM_TAPS-1:0][COORD_W-1:0] tap_coords_t;

  // Load enables of the lane stages
  typedef struct packed {
    logic s4;
    logic s5;
    logic s6;
    logic s7;
    logic s8;
    logic s9;
  } lane_en_t;

  // Saturated result of one lane
  typedef struct packed {
    logic signed [COORD_W-1:0] pos;
    logic signed [COORD_W-1:0] tan;
    logic                      clip;
  } lane_res_t;

endpackage
`default_nettype wire

// ===== hdl/closed_catmull_rom_evaluator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// closed_catmull_rom_evaluator_top: closed uniform Catmull-Rom evaluator
// Loads control points into a ring store and evaluates position and
// derivative at a global curve parameter, Q16.16 with saturation.
// ---------------------------------------------------------------------------
//
//  channel  direction  handshake        payload
//  in_      input      in_valid/ready   ccr_pkg::in_item_t  (load or evaluate)
//  out_     output     out_valid/ready  ccr_pkg::out_item_t (one per evaluate)
//  cfg      input      APB psel/penable point_count register at byte address 0
//
//  One transaction enters per cycle while in_ready is high; an evaluate result
//  passes through the ten-stage datapath (input register, index stage, store
//  read, coefficients, five Horner stages alternating multiply and round/add,
//  output register).
//  A load writes the store in the second stage and produces no result.
//  Reset clears all stage valid bits and sets point_count to 4; store contents
//  stay undefined until loaded, so there is no clearing pass.
//  A stalled output holds its stage; earlier stages keep filling bubbles.
// ---------------------------------------------------------------------------
module closed_catmull_rom_evaluator_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ccr_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ccr_pkg::out_item_t                out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ccr_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [ccr_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [ccr_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import ccr_pkg::*;

  // Configuration
  logic [CNT_W-1:0] count_r;
  logic             cfg_wr;
  cfg_reg_t         cfg_idx;

  // Stage valids and load enables
  logic [NUM_STAGES:1] vld_r;
  logic [NUM_STAGES:1] adv;

  // Stage 1: input register
  in_item_t in1_r;
  // Stage 2: indices and fraction
  logic                               kind2_r;
  logic [PT_IDX_W-1:0]                slot2_r;
  point_t                             pt2_r;
  logic [T_W-1:0]                     f2_r;
  logic [NUM_TAPS-1:0][PT_IDX_W-1:0]  idx2_r;
  // Stage 3: fraction beside the store read register
  logic [T_W-1:0]                     f3_r;
  // Stage 10: output register
  out_item_t out_r;

  // Index computation
  logic [CNT_W-1:0]                   cnt_eff;
  logic [T_W+CNT_W-1:0]               product;
  logic [CNT_W-1:0]                   seg, seg_inc, i2_w, i2_inc, i3_w, i0_w;
  logic [NUM_TAPS-1:0][PT_IDX_W-1:0]  idx_nxt;

  // Store and lanes
  logic                    ram_wr;
  point_t                  rd_pt [NUM_TAPS];
  tap_coords_t             lane_taps [NUM_AXES];
  lane_res_t               lane_res [NUM_AXES];
  lane_en_t                lane_en;
  out_item_t               out_nxt;

  // Configuration port: always ready, write on the access phase
  assign pready  = 1'b1;
  assign cfg_idx = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
    end else if (cfg_wr && (cfg_idx == REG_POINT_COUNT)) begin
      count_r <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_POINT_COUNT: prdata = CFG_DATA_W'(count_r);
      default:         prdata = '0;
    endcase
  end

  // Stage load enables: a stage loads when empty or when its content moves on
  always_comb begin
    adv[NUM_STAGES] = !vld_r[NUM_STAGES] || out_ready;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_ready = adv[1];

  // Advance valid bits; loads drop out after the store write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 1; k <= NUM_STAGES; k++) begin
        if (adv[k]) begin
          if (k == 1) begin
            vld_r[k] <= in_valid;
          end else if (k == 3) begin
            vld_r[k] <= vld_r[2] && (kind2_r == KIND_EVAL);
          end else begin
            vld_r[k] <= vld_r[k-1];
          end
        end
      end
    end
  end

  // Scale the parameter into segment and fraction, pick taps with wraparound
  always_comb begin
    if (count_r == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (count_r > CNT_W'(MAX_POINTS)) begin
      cnt_eff = CNT_W'(MAX_POINTS);
    end else begin
      cnt_eff = count_r;
    end
    product = (T_W+CNT_W)'(in1_r.global_t) * (T_W+CNT_W)'(cnt_eff);
    seg     = product[T_W +: CNT_W];
    if (seg >= cnt_eff) begin
      seg = cnt_eff - CNT_W'(1);
    end
    seg_inc = seg + CNT_W'(1);
    i2_w    = (seg_inc >= cnt_eff) ? '0 : seg_inc;
    i2_inc  = i2_w + CNT_W'(1);
    i3_w    = (i2_inc >= cnt_eff) ? '0 : i2_inc;
    i0_w    = (seg == '0) ? (cnt_eff - CNT_W'(1)) : (seg - CNT_W'(1));
    idx_nxt[0] = i0_w[PT_IDX_W-1:0];
    idx_nxt[1] = seg[PT_IDX_W-1:0];
    idx_nxt[2] = i2_w[PT_IDX_W-1:0];
    idx_nxt[3] = i3_w[PT_IDX_W-1:0];
  end

  // Front stages
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      in1_r <= in_data;
    end
    if (adv[2]) begin
      kind2_r <= in1_r.kind;
      slot2_r <= in1_r.point_slot;
      pt2_r   <= {in1_r.coord_z, in1_r.coord_y, in1_r.coord_x};
      f2_r    <= product[T_W-1:0];
      idx2_r  <= idx_nxt;
    end
    if (adv[3]) begin
      f3_r <= f2_r;
    end
  end

  // Point store: one copy per tap, every load written to all
  assign ram_wr = vld_r[2] && (kind2_r == KIND_LOAD) && adv[3];

  for (genvar t = 0; t < NUM_TAPS; t++) begin : g_tap
    ccr_ram #(
      .WIDTH ($bits(point_t)),
      .DEPTH (MAX_POINTS)
    ) u_ram (
      .clk     (clk),
      .wr_en   (ram_wr),
      .wr_addr (slot2_r),
      .wr_data (pt2_r),
      .rd_en   (adv[3]),
      .rd_addr (idx2_r[t]),
      .rd_data (rd_pt[t])
    );
  end

  // Regroup the taps per axis
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      for (int t = 0; t < NUM_TAPS; t++) begin
        lane_taps[a][t] = rd_pt[t][a];
      end
    end
  end

  assign lane_en = '{s4: adv[4], s5: adv[5], s6: adv[6], s7: adv[7], s8: adv[8], s9: adv[9]};

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    ccr_lane u_lane (
      .clk  (clk),
      .en   (lane_en),
      .taps (lane_taps[a]),
      .frac (f3_r),
      .res  (lane_res[a])
    );
  end

  // Output register
  always_comb begin
    out_nxt.pos_x     = lane_res[0].pos;
    out_nxt.pos_y     = lane_res[1].pos;
    out_nxt.pos_z     = lane_res[2].pos;
    out_nxt.tangent_x = lane_res[0].tan;
    out_nxt.tangent_y = lane_res[1].tan;
    out_nxt.tangent_z = lane_res[2].tan;
    out_nxt.clipped   = lane_res[0].clip | lane_res[1].clip | lane_res[2].clip;
  end

  always_ff @(posedge clk) begin
    if (adv[NUM_STAGES]) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = vld_r[NUM_STAGES];
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== hdl/ccr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ccr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; the read register holds
// while the read enable is low.
// ---------------------------------------------------------------------------
module ccr_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== hdl/ccr_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ccr_lane: Catmull-Rom arithmetic for one axis
// Forms the doubled basis coefficients from four taps, runs the Horner
// chains for position and derivative (one multiply stage, one round/add
// stage per level) and saturates both results.
// ---------------------------------------------------------------------------
module ccr_lane (
  input  logic                         clk,
  input  ccr_pkg::lane_en_t            en,
  input  ccr_pkg::tap_coords_t         taps,
  input  logic [ccr_pkg::T_W-1:0]      frac,
  output ccr_pkg::lane_res_t           res
);
  import ccr_pkg::*;

  localparam int RND_HALF = 1 << (T_W - 1);

  // Scale back a product with a Q0.16 fraction, rounded half toward plus infinity
  function automatic logic signed [ACC_W-1:0] round_frac(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p + PROD_W'(RND_HALF);
    return s[ACC_W+T_W-1:T_W];
  endfunction

  // floor((v + 1) / 2)
  function automatic logic signed [ACC_W-1:0] half_up(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W:0] w;
    w = (ACC_W+1)'(v) + (ACC_W+1)'(1);
    return w[ACC_W:1];
  endfunction

  // Clamp to the coordinate range; top bit flags a clamp
  function automatic logic [COORD_W:0] clamp(input logic signed [ACC_W:0] v);
    logic fits;
    fits = (&v[ACC_W:COORD_W-1]) || !(|v[ACC_W:COORD_W-1]);
    if (fits) begin
      return {1'b0, v[COORD_W-1:0]};
    end else if (v[ACC_W]) begin
      return {1'b1, 1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b1, 1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  // Stage 4 registers: coefficients
  logic signed [ACC_W-1:0] a3_4_r, a2_4_r, a1_4_r, a3x3_4_r, a2x2_4_r, p1_4_r;
  logic [T_W-1:0]          f4_r;
  // Stage 5: first products
  logic signed [PROD_W-1:0] ph5_r, pd5_r;
  logic signed [ACC_W-1:0]  a2_5_r, a2x2_5_r, a1_5_r, p1_5_r;
  logic [T_W-1:0]           f5_r;
  // Stage 6: first Horner sums
  logic signed [ACC_W-1:0] h6_r, d6_r, a1_6_r, p1_6_r;
  logic [T_W-1:0]          f6_r;
  // Stage 7: second products
  logic signed [PROD_W-1:0] ph7_r, pd7_r;
  logic signed [ACC_W-1:0]  a1_7_r, p1_7_r;
  logic [T_W-1:0]           f7_r;
  // Stage 8: second Horner sums
  logic signed [ACC_W-1:0] h8_r, d8_r, p1_8_r;
  logic [T_W-1:0]          f8_r;
  // Stage 9: last position product
  logic signed [PROD_W-1:0] ph9_r;
  logic signed [ACC_W-1:0]  d9_r, p1_9_r;

  logic signed [ACC_W-1:0] p0, p1, p2, p3;
  logic signed [ACC_W-1:0] a3_nxt, a2_nxt, a1_nxt, a3x3_nxt, a2x2_nxt;
  logic signed [ACC_W:0]   pos_w, tan_w;
  logic [COORD_W:0]        pos_sat, tan_sat;

  // Form doubled basis coefficients from the taps
  always_comb begin
    p0       = ACC_W'(signed'(taps[0]));
    p1       = ACC_W'(signed'(taps[1]));
    p2       = ACC_W'(signed'(taps[2]));
    p3       = ACC_W'(signed'(taps[3]));
    a3_nxt   = p3 - p0 + (p1 <<< 1) + p1 - (p2 <<< 1) - p2;
    a2_nxt   = (p0 <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
    a1_nxt   = p2 - p0;
    a3x3_nxt = (a3_nxt <<< 1) + a3_nxt;
    a2x2_nxt = a2_nxt <<< 1;
  end

  // Advance the Horner pipeline
  always_ff @(posedge clk) begin
    if (en.s4) begin
      a3_4_r   <= a3_nxt;
      a2_4_r   <= a2_nxt;
      a1_4_r   <= a1_nxt;
      a3x3_4_r <= a3x3_nxt;
      a2x2_4_r <= a2x2_nxt;
      p1_4_r   <= p1;
      f4_r     <= frac;
    end
    if (en.s5) begin
      ph5_r    <= PROD_W'(a3_4_r) * PROD_W'(signed'({1'b0, f4_r}));
      pd5_r    <= PROD_W'(a3x3_4_r) * PROD_W'(signed'({1'b0, f4_r}));
      a2_5_r   <= a2_4_r;
      a2x2_5_r <= a2x2_4_r;
      a1_5_r   <= a1_4_r;
      p1_5_r   <= p1_4_r;
      f5_r     <= f4_r;
    end
    if (en.s6) begin
      h6_r   <= round_frac(ph5_r) + a2_5_r;
      d6_r   <= round_frac(pd5_r) + a2x2_5_r;
      a1_6_r <= a1_5_r;
      p1_6_r <= p1_5_r;
      f6_r   <= f5_r;
    end
    if (en.s7) begin
      ph7_r  <= PROD_W'(h6_r) * PROD_W'(signed'({1'b0, f6_r}));
      pd7_r  <= PROD_W'(d6_r) * PROD_W'(signed'({1'b0, f6_r}));
      a1_7_r <= a1_6_r;
      p1_7_r <= p1_6_r;
      f7_r   <= f6_r;
    end
    if (en.s8) begin
      h8_r   <= round_frac(ph7_r) + a1_7_r;
      d8_r   <= round_frac(pd7_r) + a1_7_r;
      p1_8_r <= p1_7_r;
      f8_r   <= f7_r;
    end
    if (en.s9) begin
      ph9_r  <= PROD_W'(h8_r) * PROD_W'(signed'({1'b0, f8_r}));
      d9_r   <= d8_r;
      p1_9_r <= p1_8_r;
    end
  end

  // Finish position and derivative, then saturate
  always_comb begin
    pos_w    = (ACC_W+1)'(p1_9_r) + (ACC_W+1)'(half_up(round_frac(ph9_r)));
    tan_w    = (ACC_W+1)'(half_up(d9_r));
    pos_sat  = clamp(pos_w);
    tan_sat  = clamp(tan_w);
    res.pos  = pos_sat[COORD_W-1:0];
    res.tan  = tan_sat[COORD_W-1:0];
    res.clip = pos_sat[COORD_W] | tan_sat[COORD_W];
  end

endmodule
`default_nettype wire
